// ----- sv/nol_pkg.sv -----
// Package for the ND option locator: word types, status codes, header size lookup.
package nol_pkg;

  localparam int unsigned MAX_MSG_BYTES = 2048;

  typedef enum logic [2:0] {
    StFound       = 3'd0,
    StAbsent      = 3'd1,
    StUnsupported = 3'd2,
    StZeroLen     = 3'd3,
    StTooLong     = 3'd4
  } status_e;

  localparam logic [7:0] KindRtrSol  = 8'd133;
  localparam logic [7:0] KindRtrAdv  = 8'd134;
  localparam logic [7:0] KindNbrSol  = 8'd135;
  localparam logic [7:0] KindNbrAdv  = 8'd136;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] wanted_type;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] option_offset;
    logic [7:0]  option_units;
    logic [7:0]  message_kind;
  } out_word_t;

  // fixed header size in bytes, 0 for unsupported kinds
  function automatic logic [4:0] header_size(logic [7:0] kind);
    logic [4:0] hs;
    unique case (kind)
      KindRtrSol: hs = 5'd8;
      KindRtrAdv: hs = 5'd16;
      KindNbrSol: hs = 5'd24;
      KindNbrAdv: hs = 5'd24;
      default:    hs = 5'd0;
    endcase
    return hs;
  endfunction

endpackage

// ----- sv/nd_option_locator_top.sv -----
// ND option locator: streams one ICMPv6 neighbor discovery message and finds one option.
//
// Input channel (in_valid_i/in_ready_o/in_word_i): one message byte per word, byte 0 is
// the ICMPv6 type; wanted_type is sampled with byte 0, last_byte flags the final byte.
// Output channel (out_valid_o/out_ready_i/out_word_o): one result word per message,
// produced by the word carrying last_byte: status, option offset and length units of
// the first option of the wanted type, and the message type.
// The result word is registered and valid the cycle after the last byte is accepted.
// Throughput: one byte per cycle; the parse state sits in registers and each byte
// needs one compare against the next option start and one add to advance it.
// A stalled result word is held in the output register; non-final bytes of the next
// message are still accepted meanwhile, and only a final byte waits for the slot.
// Reset (rst_ni low, asynchronous) returns to the start of a message with no result
// pending.
// MaxMsgBytes sets where a message counts as too long; the position counter
// saturates at that value.
module nd_option_locator_top #(
  parameter int unsigned MaxMsgBytes = nol_pkg::MAX_MSG_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  nol_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output nol_pkg::out_word_t out_word_o
);
  import nol_pkg::*;

  localparam int unsigned PosW = $clog2(MaxMsgBytes + 1);
  localparam int unsigned NosW = $clog2(MaxMsgBytes + 2049);

  logic [PosW-1:0] pos_q, pos_d;
  logic [NosW-1:0] nos_q, nos_d;
  logic [7:0]      kind_q, kind_d;
  logic [7:0]      sought_q, sought_d;
  logic [10:0]     moff_q, moff_d;
  logic [7:0]      munits_q, munits_d;
  status_e         pstat_q, pstat_d;
  logic            tmatch_q, tmatch_d;

  logic            out_valid_q;
  out_word_t       out_word_q;
  logic            in_acc;
  logic            res_acc;
  logic [NosW-1:0] pos_ext;
  logic [7:0]      b;

  assign in_ready_o = !out_valid_q || out_ready_i || !in_word_i.last_byte;
  assign in_acc     = in_valid_i && in_ready_o;
  assign res_acc    = in_acc && in_word_i.last_byte;
  assign b          = in_word_i.data_byte;
  assign pos_ext    = NosW'(pos_q);

  always_comb begin
    pos_d    = pos_q;
    nos_d    = nos_q;
    kind_d   = kind_q;
    sought_d = sought_q;
    moff_d   = moff_q;
    munits_d = munits_q;
    pstat_d  = pstat_q;
    tmatch_d = tmatch_q;
    if (pos_q == '0) begin
      kind_d   = b;
      sought_d = in_word_i.wanted_type;
      moff_d   = '0;
      munits_d = '0;
      tmatch_d = 1'b0;
      nos_d    = NosW'(header_size(b));
      pstat_d  = (header_size(b) == 5'd0) ? StUnsupported : StAbsent;
    end else if (pstat_q != StUnsupported) begin
      if (pos_q >= PosW'(MaxMsgBytes)) begin
        pstat_d = StTooLong;
      end else if (pstat_q == StAbsent) begin
        if (pos_ext == nos_q) begin
          tmatch_d = (b == sought_q);
          if (b == sought_q) begin
            moff_d = 11'(pos_q);
            if (in_word_i.last_byte) begin
              pstat_d = StZeroLen;
            end
          end
        end else if (pos_ext == nos_q + NosW'(1)) begin
          if (b == 8'd0) begin
            pstat_d = StZeroLen;
          end else if (tmatch_q) begin
            munits_d = b;
            pstat_d  = StFound;
          end else begin
            nos_d = nos_q + NosW'({b, 3'b000});
          end
        end
      end
    end
    if (pos_q < PosW'(MaxMsgBytes)) begin
      pos_d = pos_q + PosW'(1);
    end
    if (in_word_i.last_byte) begin
      pos_d    = '0;
      tmatch_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      nos_q    <= '0;
      kind_q   <= '0;
      sought_q <= '0;
      moff_q   <= '0;
      munits_q <= '0;
      pstat_q  <= StAbsent;
      tmatch_q <= 1'b0;
    end else if (in_acc) begin
      pos_q    <= pos_d;
      nos_q    <= nos_d;
      kind_q   <= kind_d;
      sought_q <= sought_d;
      moff_q   <= moff_d;
      munits_q <= munits_d;
      pstat_q  <= pstat_d;
      tmatch_q <= tmatch_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_acc) begin
      out_word_q.status        <= pstat_d;
      out_word_q.option_offset <= (pstat_d == StFound) ? moff_d : 11'd0;
      out_word_q.option_units  <= (pstat_d == StFound) ? munits_d : 8'd0;
      out_word_q.message_kind  <= kind_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- sv/nol_checker.sv -----
// Port-level checker for the ND option locator, bound to the top level.
module nol_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input nol_pkg::out_word_t out_word_o
);
  import nol_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.status <= StTooLong)
    else $error("status code out of range");

  a_nonfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != StFound |->
      out_word_o.option_offset == 11'd0 && out_word_o.option_units == 8'd0)
    else $error("offset or units set without a match");

  a_found_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == StFound |-> out_word_o.option_units != 8'd0)
    else $error("found option with zero length");

  a_unsup_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == StUnsupported |->
      out_word_o.message_kind != KindRtrSol && out_word_o.message_kind != KindRtrAdv &&
      out_word_o.message_kind != KindNbrSol && out_word_o.message_kind != KindNbrAdv)
    else $error("supported kind reported as unsupported");

endmodule

bind nd_option_locator_top nol_checker u_nol_checker (.*);
